@@ hw/rtl/magnetometer_trim_compensation_top_macros.svh @@
// assertion helpers for the top block, which checks itself
`ifndef MAGNETOMETER_TRIM_COMPENSATION_TOP_MACROS_SVH
`define MAGNETOMETER_TRIM_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication, quiet while in reset
`define MTC_ASSERT_IMP(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, quiet while in reset
`define MTC_ASSERT_NXT(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ hw/rtl/mtc_pkg.sv @@
package mtc_pkg;

	// output format and soft-iron gain format
	localparam int OUT_W   = 20;
	localparam int GAIN_FB = 12;

	// raw sample widths
	localparam int RAW_XY_W = 13;
	localparam int RAW_Z_W  = 15;
	localparam int HALL_W   = 14;

	// shared divider: dividend and divisor widths, one quotient bit per stage
	localparam int DIV_NW = 34;
	localparam int DIV_DW = 18;

	// signed z compensation result
	localparam int CZ_W = DIV_NW + 1;

	localparam logic [RAW_XY_W-1:0] XY_SENTINEL = {1'b1, {(RAW_XY_W-1){1'b0}}};
	localparam logic [RAW_Z_W-1:0]  Z_SENTINEL  = {1'b1, {(RAW_Z_W-1){1'b0}}};

	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic [15:0] GAIN_ONE = 16'(2**GAIN_FB);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TRIM_XY,
		REG_TRIM_Z,
		REG_OFF_X,
		REG_OFF_Y,
		REG_OFF_Z,
		REG_GAIN_X,
		REG_GAIN_Y,
		REG_GAIN_Z
	} mtc_cfg_reg_t;

	// trim words, lowest field last
	typedef struct packed {
		logic [15:0]       xyz1;
		logic signed [7:0] xy2;
		logic [7:0]        xy1;
		logic signed [7:0] y2;
		logic signed [7:0] x2;
		logic signed [7:0] y1;
		logic signed [7:0] x1;
	} mtc_trim_xy_t;

	typedef struct packed {
		logic signed [15:0] z4;
		logic signed [15:0] z3;
		logic signed [15:0] z2;
		logic [15:0]        z1;
	} mtc_trim_z_t;

	// hard and soft iron calibration
	typedef struct packed {
		logic signed [19:0] off_x;
		logic signed [19:0] off_y;
		logic signed [19:0] off_z;
		logic [15:0]        gain_x;
		logic [15:0]        gain_y;
		logic [15:0]        gain_z;
	} mtc_cal_t;

	// side data that rides along with the divider
	typedef struct packed {
		logic signed [RAW_XY_W-1:0] raw_x;
		logic signed [RAW_XY_W-1:0] raw_y;
		logic                       bad_x;
		logic                       bad_y;
		logic                       bad_z;
		logic                       neg_z;
	} mtc_side_t;

	// one divider lane: partial remainder, dividend shifting into quotient, divisor
	typedef struct packed {
		logic [DIV_DW-1:0] rem;
		logic [DIV_NW-1:0] dq;
		logic [DIV_DW-1:0] den;
	} mtc_div_lane_t;

	// one finished result
	typedef struct packed {
		logic             sat;
		logic             inv_z;
		logic             inv_y;
		logic             inv_x;
		logic [OUT_W-1:0] field_z;
		logic [OUT_W-1:0] field_y;
		logic [OUT_W-1:0] field_x;
	} mtc_res_t;

endpackage

@@ hw/rtl/mtc_div.sv @@
module mtc_div import mtc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  mtc_div_lane_t in_a,
	input  mtc_div_lane_t in_z,
	input  mtc_side_t     in_side,
	output logic          out_valid,
	output logic [DIV_NW-1:0] quo_a,
	output logic [DIV_NW-1:0] quo_z,
	output mtc_side_t     out_side
);

	// one restoring step: shift in next dividend bit, subtract if it fits
	function automatic mtc_div_lane_t div_step(input mtc_div_lane_t l);
		logic [DIV_DW:0] sh;
		logic [DIV_DW:0] diff;
		logic            ge;
		mtc_div_lane_t   o;
		sh    = {l.rem, l.dq[DIV_NW-1]};
		diff  = sh - {1'b0, l.den};
		ge    = (sh >= {1'b0, l.den});
		o.rem = ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
		o.dq  = {l.dq[DIV_NW-2:0], ge};
		o.den = l.den;
		return o;
	endfunction

	logic          valid_s [DIV_NW];
	mtc_div_lane_t a_s     [DIV_NW];
	mtc_div_lane_t z_s     [DIV_NW];
	mtc_side_t     side_s  [DIV_NW];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_NW; i++) valid_s[i] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int i = 1; i < DIV_NW; i++) valid_s[i] <= valid_s[i-1];
		end
	end

	// one quotient bit per stage on both lanes
	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0]    <= div_step(in_a);
			z_s[0]    <= div_step(in_z);
			side_s[0] <= in_side;
			for (int i = 1; i < DIV_NW; i++) begin
				a_s[i]    <= div_step(a_s[i-1]);
				z_s[i]    <= div_step(z_s[i-1]);
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = valid_s[DIV_NW-1];
	assign quo_a     = a_s[DIV_NW-1].dq;
	assign quo_z     = z_s[DIV_NW-1].dq;
	assign out_side  = side_s[DIV_NW-1];

endmodule

@@ hw/rtl/mtc_front.sv @@
module mtc_front import mtc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [15:0]   x_pair,
	input  logic [15:0]   y_pair,
	input  logic [15:0]   z_pair,
	input  logic [15:0]   hall_pair,
	input  mtc_trim_xy_t  txy,
	input  mtc_trim_z_t   tz,
	output logic          out_valid,
	output mtc_div_lane_t out_a,
	output mtc_div_lane_t out_z,
	output mtc_side_t     out_side
);

	logic signed [RAW_XY_W-1:0] raw_x_c, raw_y_c;
	logic signed [RAW_Z_W-1:0]  raw_z_c;
	logic [HALL_W-1:0]          rh_c;

	logic                       valid_s1, valid_s2, valid_s3;
	logic signed [RAW_XY_W-1:0] raw_x_s1, raw_y_s1, raw_x_s2, raw_y_s2;
	logic [HALL_W-1:0]          rh_s1, rh_s2;
	logic signed [16:0]         q0_s1, q1_s1, q0_s2, q4_s2;
	logic [29:0]                z1rh_s1;
	logic                       bad_x_s1, bad_y_s1, bad_z_s1;
	logic                       bad_x_s2, bad_y_s2, bad_z_s2;
	logic signed [32:0]         q2_s2;

	logic signed [16:0]         q4_c;
	logic signed [34:0]         num_c, num_mag_c;
	logic signed [18:0]         den_c, den_mag_c;

	mtc_div_lane_t              a_s3, z_s3;
	mtc_side_t                  side_s3;

	// unpack the register pairs
	assign raw_x_c = {x_pair[15:8], x_pair[7:3]};
	assign raw_y_c = {y_pair[15:8], y_pair[7:3]};
	assign raw_z_c = {z_pair[15:8], z_pair[7:1]};
	assign rh_c    = {hall_pair[15:8], hall_pair[7:2]};

	// z divisor and numerator
	assign q4_c      = $signed({tz.z2[15], tz.z2}) + $signed({2'b00, z1rh_s1[29:15]});
	assign num_c     = (35'(q0_s2) <<< 17) - 35'(q2_s2);
	assign den_c     = 19'(q4_s2) <<< 2;
	assign num_mag_c = num_c[34] ? -num_c : num_c;
	assign den_mag_c = den_c[18] ? -den_c : den_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: raw values, sentinels, z1 times hall
			raw_x_s1 <= raw_x_c;
			raw_y_s1 <= raw_y_c;
			rh_s1    <= rh_c;
			q0_s1    <= $signed({{2{raw_z_c[RAW_Z_W-1]}}, raw_z_c}) - $signed({tz.z4[15], tz.z4});
			q1_s1    <= $signed({3'b000, rh_c}) - $signed({1'b0, txy.xyz1});
			z1rh_s1  <= 30'(tz.z1) * 30'(rh_c);
			bad_x_s1 <= (raw_x_c == XY_SENTINEL) || (rh_c == '0);
			bad_y_s1 <= (raw_y_c == XY_SENTINEL) || (rh_c == '0);
			bad_z_s1 <= (raw_z_c == Z_SENTINEL) || (rh_c == '0) || (tz.z2 == '0)
				|| (tz.z1 == '0) || (txy.xyz1 == '0);

			// stage 2: z3 term and divisor
			raw_x_s2 <= raw_x_s1;
			raw_y_s2 <= raw_y_s1;
			rh_s2    <= rh_s1;
			q0_s2    <= q0_s1;
			q2_s2    <= $signed(tz.z3) * q1_s1;
			q4_s2    <= q4_c;
			bad_x_s2 <= bad_x_s1;
			bad_y_s2 <= bad_y_s1;
			bad_z_s2 <= bad_z_s1 || (q4_c == '0);

			// stage 3: divider operands as magnitudes
			a_s3.rem       <= '0;
			a_s3.dq        <= {4'b0000, txy.xyz1, 14'b0};
			a_s3.den       <= {4'b0000, rh_s2};
			z_s3.rem       <= '0;
			z_s3.dq        <= num_mag_c[DIV_NW-1:0];
			z_s3.den       <= den_mag_c[DIV_DW-1:0];
			side_s3.raw_x  <= raw_x_s2;
			side_s3.raw_y  <= raw_y_s2;
			side_s3.bad_x  <= bad_x_s2;
			side_s3.bad_y  <= bad_y_s2;
			side_s3.bad_z  <= bad_z_s2;
			side_s3.neg_z  <= num_c[34] ^ den_c[18];
		end
	end

	assign out_valid = valid_s3;
	assign out_a     = a_s3;
	assign out_z     = z_s3;
	assign out_side  = side_s3;

endmodule

@@ hw/rtl/mtc_back.sv @@
module mtc_back import mtc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DIV_NW-1:0] quo_a,
	input  logic [DIV_NW-1:0] quo_z,
	input  mtc_side_t         in_side,
	input  mtc_trim_xy_t      txy,
	input  mtc_cal_t          cal,
	output logic              out_valid,
	output mtc_res_t          out_res
);

	localparam int NB     = 10;
	localparam int R_W    = 31;
	localparam int RR_W   = 2 * R_W;
	localparam int RXY_W  = R_W + 9;
	localparam int T_W    = RXY_W - 14;
	localparam int P1_W   = 41;
	localparam int PA_W   = P1_W + 1;
	localparam int P3_W   = 10;
	localparam int S_W    = PA_W + P3_W;
	localparam int P4_W   = S_W + RAW_XY_W;
	localparam int C_W    = 50;
	localparam int D_W    = C_W + 1;
	localparam int PROD_W = D_W + 17;
	localparam int V_W    = PROD_W - GAIN_FB;

	localparam logic signed [RXY_W-1:0]  RXY_RND  = RXY_W'(16383);
	localparam logic signed [P4_W-1:0]   P4_RND   = P4_W'(8191);
	localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'((2**GAIN_FB) - 1);

	logic                    valid_s [1:NB];
	mtc_side_t               side_s  [1:NB];
	logic signed [CZ_W-1:0]  cz_s    [1:6];
	logic signed [R_W-1:0]   r_s1;
	logic signed [RR_W-1:0]  rr_s2;
	logic signed [RXY_W-1:0] rxy_s2;
	logic signed [P1_W-1:0]  p1_s3;
	logic signed [T_W-1:0]   t_s3;
	logic signed [PA_W-1:0]  pa_s4;
	logic signed [S_W-1:0]   s_s5    [2];
	logic signed [P4_W-1:0]  p4_s6   [2];
	logic signed [C_W-1:0]   c_s7    [3];
	logic signed [D_W-1:0]   d_s8    [3];
	logic signed [PROD_W-1:0] prod_s9 [3];
	mtc_res_t                res_s10;

	logic signed [CZ_W-1:0]   cz_mag_c;
	logic signed [RXY_W-1:0]  rxy_rnd_c;
	logic signed [P3_W-1:0]   p3_c      [2];
	logic signed [RAW_XY_W-1:0] raw_c   [2];
	logic signed [7:0]        t1_c      [2];
	logic signed [P4_W-1:0]   p4_rnd_c  [2];
	logic signed [C_W-1:0]    c_c       [3];
	logic signed [19:0]       off_c     [3];
	logic [15:0]              gain_c    [3];
	logic                     bad_c     [3];
	logic signed [PROD_W-1:0] prod_rnd_c [3];
	logic signed [V_W-1:0]    v_c       [3];
	logic [V_W-OUT_W:0]       top_c     [3];
	logic                     sat_c     [3];
	logic [OUT_W-1:0]         field_c   [3];

	assign cz_mag_c  = {1'b0, quo_z};
	assign rxy_rnd_c = rxy_s2 + (rxy_s2[RXY_W-1] ? RXY_RND : '0);

	// per-lane operands
	always_comb begin
		raw_c[0]  = side_s[5].raw_x;
		raw_c[1]  = side_s[5].raw_y;
		t1_c[0]   = txy.x1;
		t1_c[1]   = txy.y1;
		p3_c[0]   = P3_W'($signed(txy.x2)) + P3_W'(160);
		p3_c[1]   = P3_W'($signed(txy.y2)) + P3_W'(160);
		off_c[0]  = cal.off_x;
		off_c[1]  = cal.off_y;
		off_c[2]  = cal.off_z;
		gain_c[0] = cal.gain_x;
		gain_c[1] = cal.gain_y;
		gain_c[2] = cal.gain_z;
		bad_c[0]  = side_s[6].bad_x;
		bad_c[1]  = side_s[6].bad_y;
		bad_c[2]  = side_s[6].bad_z;
	end

	// x and y: truncate toward zero and add x1 or y1 offset term; all three axes force to zero on invalid
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			p4_rnd_c[i] = p4_s6[i] + (p4_s6[i][P4_W-1] ? P4_RND : '0);
			c_c[i] = bad_c[i] ? '0
				: C_W'(p4_rnd_c[i] >>> 13) + (C_W'(t1_c[i]) <<< 3);
		end
		c_c[2] = bad_c[2] ? '0 : C_W'(cz_s[6]);
	end

	// scale, truncate toward zero and clip
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_rnd_c[i] = prod_s9[i] + (prod_s9[i][PROD_W-1] ? PROD_RND : '0);
			v_c[i]        = prod_rnd_c[i][PROD_W-1:GAIN_FB];
			top_c[i]      = v_c[i][V_W-1:OUT_W-1];
			sat_c[i]      = !((&top_c[i]) || !(|top_c[i]));
			field_c[i]    = sat_c[i] ? (v_c[i][V_W-1] ? OUT_MIN : OUT_MAX)
				: v_c[i][OUT_W-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NB; i++) valid_s[i] <= 1'b0;
		end else if (en) begin
			valid_s[1] <= in_valid;
			for (int i = 2; i <= NB; i++) valid_s[i] <= valid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= in_side;
			for (int i = 2; i <= NB; i++) side_s[i] <= side_s[i-1];

			// stage 1: centre the hall ratio, sign the z quotient
			r_s1     <= $signed({1'b0, quo_a[29:0]}) - R_W'(16384);
			cz_s[1]  <= in_side.neg_z ? -cz_mag_c : cz_mag_c;
			for (int i = 2; i <= 6; i++) cz_s[i] <= cz_s[i-1];

			// stage 2: square and xy1 term
			rr_s2  <= r_s1 * r_s1;
			rxy_s2 <= r_s1 * $signed({1'b0, txy.xy1});

			// stage 3: xy2 term and scaled xy1 term
			p1_s3 <= txy.xy2 * $signed({1'b0, rr_s2[59:28]});
			t_s3  <= rxy_rnd_c[RXY_W-1:14];

			// stage 4: shared polynomial plus 256
			pa_s4 <= PA_W'(p1_s3) + PA_W'(t_s3) + PA_W'(256);

			// stage 5 and 6: per-axis sensitivity then raw sample
			for (int i = 0; i < 2; i++) begin
				s_s5[i]  <= pa_s4 * p3_c[i];
				p4_s6[i] <= raw_c[i] * s_s5[i];
			end

			// stage 7 to 9: compensated value, hard iron, soft iron
			for (int i = 0; i < 3; i++) begin
				c_s7[i]    <= c_c[i];
				d_s8[i]    <= D_W'(c_s7[i]) - D_W'(off_c[i]);
				prod_s9[i] <= d_s8[i] * $signed({1'b0, gain_c[i]});
			end

			// stage 10: clipped result
			res_s10.field_x <= field_c[0];
			res_s10.field_y <= field_c[1];
			res_s10.field_z <= field_c[2];
			res_s10.inv_x   <= side_s[9].bad_x;
			res_s10.inv_y   <= side_s[9].bad_y;
			res_s10.inv_z   <= side_s[9].bad_z;
			res_s10.sat     <= sat_c[0] || sat_c[1] || sat_c[2];
		end
	end

	assign out_valid = valid_s[NB];
	assign out_res   = res_s10;

endmodule

@@ hw/rtl/magnetometer_trim_compensation_top.sv @@
// Hall magnetometer trim compensation with hard and soft iron calibration.
// Input stream: one beat per data burst, tdata holds the x, y, z and hall
// register pairs. Output stream: one beat per input beat, in order, with the
// three calibrated fields in 1/16 microtesla and the invalid and clip flags.
// Configuration: a write channel, ready once out of reset; the user must write trims,
// offsets and gains while no burst is in flight; the block does not enforce it.
// From an accepted input beat to the output beat being shown there are 3
// operand stages, 34 stages of the shared restoring divider (one quotient
// bit per stage, hall ratio and z lanes side by side), 10 stages of
// polynomial, calibration and clipping, and the output register.
// Throughput is one beat per cycle while the output is taken.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the next; with the skid occupied the whole pipeline
// freezes and s_axis_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits, the offsets and trims to zero and the gains
// to unity; the block is ready from the cycle after reset is released.
`include "magnetometer_trim_compensation_top_macros.svh"

module magnetometer_trim_compensation_top import mtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // x_pair, y_pair, z_pair, hall_pair
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // field_x, field_y, field_z, zero fill
	output logic [3:0]  m_axis_tuser,   // invalid_x, invalid_y, invalid_z, saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	mtc_trim_xy_t  trim_xy_q;
	mtc_trim_z_t   trim_z_q;
	mtc_cal_t      cal_q;

	logic          en;
	logic          ready_q;
	logic          front_valid, div_valid, back_valid;
	mtc_div_lane_t front_a, front_z;
	mtc_side_t     front_side, div_side;
	logic [DIV_NW-1:0] quo_a, quo_z;
	mtc_res_t      back_res;

	mtc_res_t      out_q, skid_q;
	logic          out_v_q, skid_v_q;
	logic          take, pipe_out;

	// ready from the cycle after reset is released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	// pipeline moves unless the skid beat is waiting
	assign en            = !skid_v_q;
	assign s_axis_tready = en && ready_q;
	assign cfg_ready     = ready_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_xy_q    <= '0;
			trim_z_q     <= '0;
			cal_q.off_x  <= '0;
			cal_q.off_y  <= '0;
			cal_q.off_z  <= '0;
			cal_q.gain_x <= GAIN_ONE;
			cal_q.gain_y <= GAIN_ONE;
			cal_q.gain_z <= GAIN_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TRIM_XY: trim_xy_q    <= cfg_data;
				REG_TRIM_Z:  trim_z_q     <= cfg_data;
				REG_OFF_X:   cal_q.off_x  <= cfg_data[19:0];
				REG_OFF_Y:   cal_q.off_y  <= cfg_data[19:0];
				REG_OFF_Z:   cal_q.off_z  <= cfg_data[19:0];
				REG_GAIN_X:  cal_q.gain_x <= cfg_data[15:0];
				REG_GAIN_Y:  cal_q.gain_y <= cfg_data[15:0];
				REG_GAIN_Z:  cal_q.gain_z <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	mtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid && s_axis_tready),
		.x_pair    (s_axis_tdata[15:0]),
		.y_pair    (s_axis_tdata[31:16]),
		.z_pair    (s_axis_tdata[47:32]),
		.hall_pair (s_axis_tdata[63:48]),
		.txy       (trim_xy_q),
		.tz        (trim_z_q),
		.out_valid (front_valid),
		.out_a     (front_a),
		.out_z     (front_z),
		.out_side  (front_side)
	);

	mtc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_a      (front_a),
		.in_z      (front_z),
		.in_side   (front_side),
		.out_valid (div_valid),
		.quo_a     (quo_a),
		.quo_z     (quo_z),
		.out_side  (div_side)
	);

	mtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.quo_a     (quo_a),
		.quo_z     (quo_z),
		.in_side   (div_side),
		.txy       (trim_xy_q),
		.cal       (cal_q),
		.out_valid (back_valid),
		.out_res   (back_res)
	);

	assign take     = out_v_q && m_axis_tready;
	assign pipe_out = en && back_valid;

	// output register with skid beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_v_q || take) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= pipe_out;
		end else if (pipe_out) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_v_q || take) out_q <= skid_q;
		end else if (!out_v_q || take) begin
			out_q <= back_res;
		end else if (pipe_out) begin
			skid_q <= back_res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'b0000, out_q.field_z, out_q.field_y, out_q.field_x};
	assign m_axis_tuser  = {out_q.sat, out_q.inv_z, out_q.inv_y, out_q.inv_x};

	// checks
	`MTC_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid beat held with empty output")
	`MTC_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_v_q), $past(out_v_q && !m_axis_tready), "skid filled without a stall")
	`MTC_ASSERT_IMP(a_sat_at_rail, out_v_q && out_q.sat, (out_q.field_x == OUT_MAX) || (out_q.field_x == OUT_MIN) || (out_q.field_y == OUT_MAX) || (out_q.field_y == OUT_MIN) || (out_q.field_z == OUT_MAX) || (out_q.field_z == OUT_MIN), "clip flag without a field at a rail")

endmodule
